// ----- hw/rtl/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants for the point-in-polygon test
// Operation codes, controller states, datapath widths and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int COORD_W = 31;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic clear;
        logic append;
        logic start_query;
        logic read_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic read_last;
        logic pipe_busy;
        logic out_free;
    } t_status;

endpackage

// ----- hw/rtl/point_in_polygon_test.sv -----
// Point-in-polygon test by crossing parity. The block stores one closed
// polygon of up to MAX_VERTICES signed 31-bit vertices and answers queries.
// Each request carries an op code: clear empties the polygon and the overflow
// flag, append stores a vertex (dropped and flagged once the store is full),
// query returns whether the point is inside by exact integer crossing parity,
// together with the overflow flag; op code 3 is taken and ignored. Only a
// query produces a result. A query over n stored vertices makes n + 1 vertex
// reads, runs them through a three-stage difference / multiply / accumulate
// pipeline and then hands the result off, paced by the single read port of
// the vertex memories, one edge per cycle; an empty polygon skips the walk
// and goes straight to the hand-off. No request is taken while a query is in
// progress or its result waits to be loaded into the output register.
// ----------------------------------------------------------------------------
// point_in_polygon_test: crossing-number point-in-polygon top level
// Joins the sequencing controller and the vertex / arithmetic datapath.
// ----------------------------------------------------------------------------
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Request channel
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_op,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    // Result channel
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_inside_res,
    output logic                      o_vertex_overflow
);

    t_cmd    w_cmd;
    t_status w_status;

    // Decode requests and sequence the edge walk
    pip_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_op     (i_op),
        .i_status (w_status),
        .o_ready  (o_ready),
        .o_cmd    (w_cmd)
    );

    // Hold the polygon, evaluate edges, and drive the result register
    pip_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_coord_x         (i_coord_x),
        .i_coord_y         (i_coord_y),
        .i_ready           (i_ready),
        .o_status          (w_status),
        .o_valid           (o_valid),
        .o_inside_res      (o_inside_res),
        .o_vertex_overflow (o_vertex_overflow)
    );

endmodule

// ----- hw/rtl/pip_ram.sv -----
// ----------------------------------------------------------------------------
// pip_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pip_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/pip_ctrl.sv -----
// ----------------------------------------------------------------------------
// pip_ctrl: sequencing controller for the point-in-polygon test
// Decodes accepted requests and steps a query through the edge walk, the
// pipeline drain and the result hand-off.
// ----------------------------------------------------------------------------
module pip_ctrl
    import pip_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_op,
    input  t_status    i_status,
    output logic       o_ready,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_op == OP_QUERY)) begin
                    n_state = i_status.count_zero ? S_FINISH : S_WALK;
                end
            end
            S_WALK: begin
                if (i_status.read_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (w_accept) begin
                    unique case (i_op)
                        OP_CLEAR:  o_cmd.clear       = 1'b1;
                        OP_APPEND: o_cmd.append      = 1'b1;
                        OP_QUERY:  o_cmd.start_query = 1'b1;
                        default:   o_cmd             = '0;
                    endcase
                end
            end
            S_WALK: begin
                o_cmd.read_step = 1'b1;
            end
            S_DRAIN: begin
                o_cmd = '0;
            end
            S_FINISH: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- hw/rtl/pip_datapath.sv -----
// ----------------------------------------------------------------------------
// pip_datapath: vertex storage and crossing-number datapath
// Holds the vertex memories, vertex count and overflow flag, walks the edges
// through a read / difference / multiply / accumulate pipeline, and owns
// the result register.
// ----------------------------------------------------------------------------
module pip_datapath
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic                      i_ready,
    output t_status                   o_status,
    output logic                      o_valid,
    output logic                      o_inside_res,
    output logic                      o_vertex_overflow
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    // Control state
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [CW-1:0] r_rd_idx;
    logic          r_v1;
    logic          r_v1_first;
    logic          r_v2;
    logic          r_v3;
    logic          r_inside;
    logic          r_out_valid;

    // Payload
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic signed [COORD_W-1:0] r_xj;
    logic signed [COORD_W-1:0] r_yj;
    logic signed [DIFF_W-1:0]  r_dxp;
    logic signed [DIFF_W-1:0]  r_dyj;
    logic signed [DIFF_W-1:0]  r_dyp;
    logic signed [DIFF_W-1:0]  r_dxj;
    logic                      r_str2;
    logic                      r_dir2;
    logic signed [PROD_W-1:0]  r_p1;
    logic signed [PROD_W-1:0]  r_p2;
    logic                      r_str3;
    logic                      r_dir3;
    logic                      r_out_inside;
    logic                      r_out_ovf;

    logic                      w_full;
    logic                      w_we;
    logic [AW-1:0]             w_raddr;
    logic [CW-1:0]             w_last_idx;
    logic [CW-1:0]             w_idx_m1;
    logic signed [COORD_W-1:0] w_xi;
    logic signed [COORD_W-1:0] w_yi;
    logic signed [PROD_W-1:0]  w_orient;
    logic                      w_flip;
    logic                      w_out_free;

    assign w_full     = (r_count == CW'(MAX_VERTICES));
    assign w_we       = i_cmd.append && !w_full;
    assign w_last_idx = r_count - CW'(1);
    assign w_idx_m1   = r_rd_idx - CW'(1);
    assign w_raddr    = (r_rd_idx == '0) ? w_last_idx[AW-1:0] : w_idx_m1[AW-1:0];

    pip_ram #(.WIDTH(COORD_W), .DEPTH(MAX_VERTICES)) u_ram_x (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_coord_x),
        .i_re    (i_cmd.read_step),
        .i_raddr (w_raddr),
        .o_rdata (w_xi)
    );

    pip_ram #(.WIDTH(COORD_W), .DEPTH(MAX_VERTICES)) u_ram_y (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_coord_y),
        .i_re    (i_cmd.read_step),
        .i_raddr (w_raddr),
        .o_rdata (w_yi)
    );

    // Crossing test on the finished products
    assign w_orient = r_p1 - r_p2;
    assign w_flip   = r_str3 && (r_dir3 ? (!w_orient[PROD_W-1] && (w_orient != '0))
                                        : w_orient[PROD_W-1]);

    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_rd_idx    <= '0;
            r_v1        <= 1'b0;
            r_v1_first  <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_inside    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (i_cmd.append) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end

            if (i_cmd.start_query) begin
                r_rd_idx <= '0;
            end else if (i_cmd.read_step) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end

            r_v1       <= i_cmd.read_step;
            r_v1_first <= i_cmd.read_step && (r_rd_idx == '0);
            r_v2       <= r_v1 && !r_v1_first;
            r_v3       <= r_v2;

            if (i_cmd.start_query) begin
                r_inside <= 1'b0;
            end else if (r_v3 && w_flip) begin
                r_inside <= !r_inside;
            end

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_query) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
        // Stage 1: edge differences against the previous vertex
        if (r_v1) begin
            r_xj  <= w_xi;
            r_yj  <= w_yi;
            r_dxp <= DIFF_W'(r_px) - DIFF_W'(w_xi);
            r_dyj <= DIFF_W'(r_yj) - DIFF_W'(w_yi);
            r_dyp <= DIFF_W'(r_py) - DIFF_W'(w_yi);
            r_dxj <= DIFF_W'(r_xj) - DIFF_W'(w_xi);
            r_str2 <= (w_yi > r_py) != (r_yj > r_py);
            r_dir2 <= (w_yi > r_yj);
        end
        // Stage 2: cross product terms
        r_p1   <= r_dxp * r_dyj;
        r_p2   <= r_dyp * r_dxj;
        r_str3 <= r_str2;
        r_dir3 <= r_dir2;
        if (i_cmd.load_out) begin
            r_out_inside <= r_inside;
            r_out_ovf    <= r_ovf;
        end
    end

    assign o_status.count_zero = (r_count == '0);
    assign o_status.read_last  = (r_rd_idx == r_count);
    assign o_status.pipe_busy  = r_v1 || r_v2 || r_v3;
    assign o_status.out_free   = w_out_free;

    assign o_valid           = r_out_valid;
    assign o_inside_res      = r_out_inside;
    assign o_vertex_overflow = r_out_ovf;

endmodule
